/* hw/rtl/mnc_pkg.sv */
// Shared types, constants and the compare-exchange phase for the median filter.
`timescale 1ns / 1ps
`default_nettype none

package mnc_pkg;

    localparam int WIN_N    = 5;                  // samples per window, odd, 3..9
    localparam int SAMPLE_W = 10;
    localparam int RUN_W    = 16;
    localparam int FILL_W   = $clog2(WIN_N);
    localparam int SORT_CYC = (WIN_N + 1) / 2;    // two transposition phases per cycle
    localparam int CNT_W    = $clog2(SORT_CYC);
    localparam int MED_IDX  = WIN_N / 2;

    localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(WIN_N - 1);
    localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(SORT_CYC - 1);
    localparam logic [RUN_W-1:0]  RUN_MAX   = '1;

    localparam logic [SAMPLE_W-1:0] CLIP_RESET  = SAMPLE_W'(1015);
    localparam logic [RUN_W-1:0]    LIMIT_RESET = RUN_W'(10);

    // configuration register indexes
    localparam logic CFG_CLIP  = 1'b0;
    localparam logic CFG_LIMIT = 1'b1;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef t_sample [WIN_N-1:0] t_window;

    typedef struct packed {
        logic    en;
        t_window data;
    } t_q_wr;

    typedef struct packed {
        logic    avail;
        t_window data;
    } t_q_rd;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SORT,
        BK_DONE
    } t_back_state;

    // One phase of odd-even transposition sort: compare-exchange the pairs
    // that start at the given parity.
    function automatic t_window sort_phase(t_window w, logic odd);
        t_window r;
        r = w;
        for (int i = 0; i < WIN_N - 1; i++) begin
            if ((i % 2 == 1) == odd && w[i] > w[i+1]) begin
                r[i]   = w[i+1];
                r[i+1] = w[i];
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/mnc_front.sv */
// Front end: accepts samples, collects windows and pushes each full window to the queue.
`timescale 1ns / 1ps
`default_nettype none

module mnc_front
    import mnc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_sample i_sample,
    input  wire logic    i_q_full,
    output t_q_wr        o_q_wr
);

    logic [FILL_W-1:0]         r_fill;
    logic [FILL_W-1:0]         n_fill;
    t_sample [WIN_N-2:0]       r_taps;
    logic                      w_accept;
    logic                      w_last;

    assign w_last     = (r_fill == FILL_LAST);
    // hold the closing sample until the queue has room for its window
    assign o_in_stall = w_last && i_q_full;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign o_q_wr.en   = w_accept && w_last;
    assign o_q_wr.data = {r_taps, i_sample};

    always_comb begin
        n_fill = r_fill;
        if (w_accept) begin
            n_fill = w_last ? '0 : r_fill + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    // window taps: order does not matter to the median
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_taps <= {r_taps[WIN_N-3:0], i_sample};
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/mnc_queue.sv */
// Two-entry window queue between the front end and the sorting back end.
`timescale 1ns / 1ps
`default_nettype none

module mnc_queue
    import mnc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_q_wr i_q_wr,
    output logic       o_q_full,
    input  wire logic  i_q_pop,
    output t_q_rd      o_q_rd
);

    t_window    r_entry [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_q_full     = r_count[1];
    assign o_q_rd.avail = (r_count != 2'd0);
    assign o_q_rd.data  = r_entry[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_q_wr.en && !i_q_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_q_wr.en && i_q_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_q_wr.en) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_q_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_q_wr.en) begin
            r_entry[r_wr_ptr] <= i_q_wr.data;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/mnc_back.sv */
// Back end: sorts each window, updates the clip streak and holds the result register.
`timescale 1ns / 1ps
`default_nettype none

module mnc_back
    import mnc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_q_rd             i_q_rd,
    output logic                   o_q_pop,
    input  wire t_sample           i_clip,
    input  wire logic [RUN_W-1:0]  i_limit,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output t_sample                o_median_value,
    output logic                   o_pegged,
    output logic                   o_streak_alarm,
    output logic [RUN_W-1:0]       o_streak_count
);

    t_back_state       r_state;
    t_back_state       n_state;
    logic [CNT_W-1:0]  r_cnt;
    t_window           r_win;
    logic [RUN_W-1:0]  r_run;
    logic [RUN_W-1:0]  n_run;
    logic              r_out_valid;
    t_sample           r_med;
    logic              r_peg;
    logic              r_alarm;
    logic              n_peg;
    logic              n_alarm;
    logic              w_out_free;
    logic              w_load;
    logic              w_pop;

    assign w_out_free = !r_out_valid || !i_out_stall;

    // control outputs
    always_comb begin
        w_load = 1'b0;
        w_pop  = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                w_pop = i_q_rd.avail;
            end
            BK_SORT: begin
                w_pop = 1'b0;
            end
            BK_DONE: begin
                w_load = w_out_free;
                w_pop  = w_out_free && i_q_rd.avail;
            end
            default: begin
                w_load = 1'b0;
                w_pop  = 1'b0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (w_pop) n_state = BK_SORT;
            end
            BK_SORT: begin
                if (r_cnt == CNT_LAST) n_state = BK_DONE;
            end
            BK_DONE: begin
                if (w_pop) begin
                    n_state = BK_SORT;
                end else if (w_load) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // streak update from the sorted window
    always_comb begin
        n_peg   = (r_win[MED_IDX] >= i_clip);
        n_run   = r_run;
        n_alarm = 1'b0;
        if (n_peg) begin
            if (r_run != RUN_MAX) begin
                n_run   = r_run + 1'b1;
                n_alarm = (n_run == i_limit);
            end
        end else begin
            n_run = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_cnt       <= '0;
            r_run       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_pop) begin
                r_cnt <= '0;
            end else if (r_state == BK_SORT) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (w_load) begin
                r_run       <= n_run;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_win <= i_q_rd.data;
        end else if (r_state == BK_SORT) begin
            r_win <= sort_phase(sort_phase(r_win, 1'b0), 1'b1);
        end
        if (w_load) begin
            r_med   <= r_win[MED_IDX];
            r_peg   <= n_peg;
            r_alarm <= n_alarm;
        end
    end

    assign o_q_pop        = w_pop;
    assign o_out_valid    = r_out_valid;
    assign o_median_value = r_med;
    assign o_pegged       = r_peg;
    assign o_streak_alarm = r_alarm;
    assign o_streak_count = r_run;

    a_pop_avail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> i_q_rd.avail)
        else $error("window popped from an empty queue");

    a_clear_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_pegged |-> o_streak_count == '0)
        else $error("streak not cleared by a median below threshold");

    a_alarm_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_streak_alarm |-> o_pegged && o_streak_count == i_limit)
        else $error("alarm raised away from the streak limit");

    a_load_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> r_state == BK_DONE && w_out_free)
        else $error("result loaded before sort finished or over a held result");

endmodule

`default_nettype wire

/* hw/rtl/median_of_n_with_clip_streak.sv */
// Top level of the windowed median filter with full-scale clip streak alarm.
`timescale 1ns / 1ps
`default_nettype none

// Samples are taken one per cycle on the input channel, unless it is stalled, and
// grouped into windows of WIN_N samples (5). The closing sample of each window pushes
// the whole window into a two-entry queue; the back end pops it, sorts it with
// odd-even transposition, two phases per cycle, and loads the result register, popping
// the next waiting window as it loads. Each result carries the median, whether it is
// at or above clip_threshold, the saturating count of consecutive pegged windows and
// a one-window alarm when that count first reaches streak_limit. The input stalls only
// on a closing sample while the queue is full.
// Register 0 is clip_threshold (bits 9:0 of the write data), register 1 streak_limit;
// write them only while the block is idle.
module median_of_n_with_clip_streak
    import mnc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [SAMPLE_W-1:0] i_sample,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [SAMPLE_W-1:0]    o_median_value,
    output logic                   o_pegged,
    output logic                   o_streak_alarm,
    output logic [RUN_W-1:0]       o_streak_count,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_idx,
    input  wire logic [RUN_W-1:0]  i_cfg_wdata
);

    t_sample           r_clip;
    logic [RUN_W-1:0]  r_limit;
    t_q_wr             w_q_wr;
    t_q_rd             w_q_rd;
    logic              w_q_full;
    logic              w_q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip  <= CLIP_RESET;
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CLIP:  r_clip  <= i_cfg_wdata[SAMPLE_W-1:0];
                CFG_LIMIT: r_limit <= i_cfg_wdata;
                default:   r_limit <= r_limit;
            endcase
        end
    end

    mnc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sample   (i_sample),
        .i_q_full   (w_q_full),
        .o_q_wr     (w_q_wr)
    );

    mnc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_wr   (w_q_wr),
        .o_q_full (w_q_full),
        .i_q_pop  (w_q_pop),
        .o_q_rd   (w_q_rd)
    );

    mnc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_rd         (w_q_rd),
        .o_q_pop        (w_q_pop),
        .i_clip         (r_clip),
        .i_limit        (r_limit),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_median_value (o_median_value),
        .o_pegged       (o_pegged),
        .o_streak_alarm (o_streak_alarm),
        .o_streak_count (o_streak_count)
    );

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench for the windowed median filter with clip streak alarm.
`timescale 1ns / 1ps

module tb_top;
    import mnc_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int SETTLE_CYC  = 4 * (SORT_CYC + 2);

    typedef struct {
        t_sample          median;
        logic             pegged;
        logic             alarm;
        logic [RUN_W-1:0] count;
    } t_median_result;

    // Tracks the window and the streak counter, and keeps the medians still to come.
    class median_scoreboard;
        t_sample          clip_level;
        logic [RUN_W-1:0] alarm_limit;
        t_sample          held [WIN_N];
        int               held_cnt;
        logic [RUN_W-1:0] pegged_run;
        t_median_result   expected_q [$];
        int               errors;

        function void clear();
            clip_level  = CLIP_RESET;
            alarm_limit = LIMIT_RESET;
            held_cnt    = 0;
            pegged_run  = '0;
            errors      = 0;
            expected_q.delete();
        endfunction

        function void write_reg(logic idx, logic [RUN_W-1:0] data);
            if (idx == CFG_CLIP) begin
                clip_level = data[SAMPLE_W-1:0];
            end else begin
                alarm_limit = data;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function t_sample window_median();
            t_sample s [WIN_N];
            t_sample v;
            int      j;
            s = held;
            for (int i = 1; i < WIN_N; i++) begin
                v = s[i];
                j = i - 1;
                while (j >= 0 && s[j] > v) begin
                    s[j+1] = s[j];
                    j--;
                end
                s[j+1] = v;
            end
            return s[MED_IDX];
        endfunction

        function void note_sample(t_sample smp);
            t_median_result r;
            held[held_cnt] = smp;
            held_cnt++;
            if (held_cnt < WIN_N) return;
            held_cnt = 0;
            r.median = window_median();
            r.pegged = (r.median >= clip_level);
            r.alarm  = 1'b0;
            if (r.pegged) begin
                // saturate: no increment and no new alarm at the top
                if (pegged_run != RUN_MAX) begin
                    pegged_run++;
                    r.alarm = (pegged_run == alarm_limit);
                end
            end else begin
                pegged_run = '0;
            end
            r.count = pegged_run;
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t ns: %s", $time, msg);
            errors++;
        endtask

        task check_result(t_sample med, logic peg, logic alarm, logic [RUN_W-1:0] cnt);
            t_median_result r;
            if (expected_q.size() == 0) begin
                report($sformatf("result with nothing expected, median %0d", med));
                return;
            end
            r = expected_q.pop_front();
            if (med !== r.median)
                report($sformatf("median_value got %0d exp %0d", med, r.median));
            if (peg !== r.pegged)
                report($sformatf("pegged got %0b exp %0b", peg, r.pegged));
            if (alarm !== r.alarm)
                report($sformatf("streak_alarm got %0b exp %0b", alarm, r.alarm));
            if (cnt !== r.count)
                report($sformatf("streak_count got %0d exp %0d", cnt, r.count));
        endtask
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    t_sample          sample;
    logic             out_valid;
    logic             out_stall;
    t_sample          median_value;
    logic             pegged;
    logic             streak_alarm;
    logic [RUN_W-1:0] streak_count;
    logic             cfg_we;
    logic             cfg_idx;
    logic [RUN_W-1:0] cfg_wdata;

    median_scoreboard sb;
    int               send_idle_pct;
    int               recv_stall_pct;
    int               cycle_count = 0;
    logic             hot_window = 1'b0;

    median_of_n_with_clip_streak u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_sample       (sample),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_median_value (median_value),
        .o_pegged       (pegged),
        .o_streak_alarm (streak_alarm),
        .o_streak_count (streak_count),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_wdata    (cfg_wdata)
    );

    always #5 clk = ~clk;

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_we) sb.write_reg(cfg_idx, cfg_wdata);
            if (in_valid && !in_stall) sb.note_sample(sample);
            if (out_valid && !out_stall)
                sb.check_result(median_value, pegged, streak_alarm, streak_count);
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL median_of_n_with_clip_streak");
            $finish;
        end
    end

    // Bias whole windows toward the threshold so that streaks build up.
    function automatic t_sample pick_sample();
        int r;
        int v;
        if (sb.held_cnt == 0) hot_window = ($urandom_range(99) < 75);
        r = $urandom_range(99);
        if (hot_window && r < 85) return t_sample'($urandom_range(1023, sb.clip_level));
        r = $urandom_range(99);
        if (r < 20) return ($urandom_range(1) != 0) ? t_sample'(1023) : t_sample'(0);
        if (r < 40) begin
            v = int'(sb.clip_level) + int'($urandom_range(4)) - 2;
            if (v < 0) v = 0;
            if (v > 1023) v = 1023;
            return t_sample'(v);
        end
        return t_sample'($urandom_range(1023));
    endfunction

    // Call at a falling edge; return at the falling edge after the transaction.
    task automatic send_sample(t_sample v);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        sample   <= v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random(int n);
        repeat (n) send_sample(pick_sample());
    endtask

    // Hold off input until every expected median is out and the back end is quiet.
    task automatic drain_all();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic configure(t_sample clip, logic [RUN_W-1:0] limit);
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_CLIP;
        // upper bits are don't-care for the clip register
        cfg_wdata <= {6'($urandom_range(63)), clip};
        @(negedge clk);
        cfg_idx   <= CFG_LIMIT;
        cfg_wdata <= limit;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        t_sample directed [25];
        directed = '{0, 0, 0, 0, 0,
                     1023, 1023, 1023, 1023, 1023,
                     1015, 1023, 0, 1015, 1014,
                     1014, 1023, 1014, 0, 1023,
                     1023, 0, 1023, 0, 512};
        sb = new;
        sb.clear();
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        sample         = '0;
        out_stall      = 1'b0;
        cfg_we         = 1'b0;
        cfg_idx        = CFG_CLIP;
        cfg_wdata      = '0;
        send_idle_pct  = 28;
        recv_stall_pct = 73;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: zero, full scale, exactly at and just below the threshold
        foreach (directed[k]) send_sample(directed[k]);
        drain_all();
        configure(512, 3);
        send_random(75);
        drain_all();
        configure(1023, 1);
        send_random(75);

        drain_all();
        send_idle_pct  = 73;
        recv_stall_pct = 28;
        configure(1, 2);
        send_random(75);
        drain_all();
        // a zero limit never fires
        configure(1000, 0);
        send_random(75);

        drain_all();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        configure(700, 4);
        send_random(75);
        drain_all();
        // every window pegs: the streak runs up to the limit and past it
        configure(0, 12);
        send_random(WIN_N * 15);
        drain_all();
        configure(1023, 5);
        send_random(40);
        drain_all();

        if (sb.errors == 0) begin
            $display("PASS median_of_n_with_clip_streak");
        end else begin
            $display("FAIL median_of_n_with_clip_streak");
        end
        $finish;
    end

endmodule
